// ===== rtl/core/sdspi_pkg.sv =====
// sdspi_pkg: types and constants for the sd card spi host sequencer
// depends on nothing
package sdspi_pkg;

   typedef enum logic [4:0] {
      PH_IDLE, PH_WAKE, PH_BUSY, PH_SEND, PH_FILL, PH_POLL, PH_OCR8, PH_OCR58,
      PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC, PH_WR_TOKEN, PH_WR_WAIT, PH_WR_DATA,
      PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY, PH_R2, PH_STOP_OK, PH_STOP_FAIL
   } phase_type;

   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_READ  = 3'd1;
   localparam logic [2:0] OP_WRITE = 3'd2;
   localparam logic [2:0] OP_XCHG  = 3'd3;
   localparam logic [2:0] OP_TICK  = 3'd4;
   localparam logic [2:0] OP_WDATA = 3'd5;

   localparam logic [1:0] REG_WR_BUSY = 2'd0;
   localparam logic [1:0] REG_RD_TOK  = 2'd1;
   localparam logic [1:0] REG_INIT    = 2'd2;
   localparam logic [1:0] REG_RETRY   = 2'd3;

   localparam logic [5:0] CMD0  = 6'd0;
   localparam logic [5:0] CMD8  = 6'd8;
   localparam logic [5:0] CMD13 = 6'd13;
   localparam logic [5:0] CMD17 = 6'd17;
   localparam logic [5:0] CMD24 = 6'd24;
   localparam logic [5:0] CMD41 = 6'd41;
   localparam logic [5:0] CMD55 = 6'd55;
   localparam logic [5:0] CMD58 = 6'd58;

   localparam logic [1:0] CARD_UNKNOWN = 2'd0;
   localparam logic [1:0] CARD_SD1     = 2'd1;
   localparam logic [1:0] CARD_SD2     = 2'd2;
   localparam logic [1:0] CARD_SDHC    = 2'd3;

   localparam int unsigned BLOCK_BYTES = 512;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] block_number;
      logic [7:0]  miso_byte;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic        transfer_valid;
      logic [7:0]  mosi_byte;
      logic        chip_select_high;
      logic        slow_clock;
      logic        read_valid;
      logic [7:0]  read_byte;
      logic        data_request;
      logic        done_res;
      logic        success;
      logic [1:0]  card_kind;
   } rsp_type;

endpackage

// ===== rtl/core/sd_card_spi_host_sequencer_unit.sv =====
// sd_card_spi_host_sequencer_unit: sd card host sequencer in spi mode, top level
// depends on sdspi_pkg
//
// a request transfer that yields a result passes the input register, then the result
// register; one item per cycle is taken, limited only by rsp_ready
// reset: synchronous active high; phase idle, card unknown, registers at defaults
module sd_card_spi_host_sequencer_unit #(
   parameter int unsigned WAKE_DUMMY_BYTES    = 10,
   parameter int unsigned RESPONSE_POLL_LIMIT = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sdspi_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sdspi_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   // configuration registers
   logic [15:0] wr_busy_to_ff, rd_tok_to_ff, init_to_ff;
   logic [7:0]  retry_lim_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_busy_to_ff <= 16'd600;
         rd_tok_to_ff  <= 16'd300;
         init_to_ff    <= 16'd2000;
         retry_lim_ff  <= 8'd10;
      end else if (csr_valid) begin
         case (csr_index)
            sdspi_pkg::REG_WR_BUSY: wr_busy_to_ff <= csr_wdata;
            sdspi_pkg::REG_RD_TOK:  rd_tok_to_ff  <= csr_wdata;
            sdspi_pkg::REG_INIT:    init_to_ff    <= csr_wdata;
            sdspi_pkg::REG_RETRY:   retry_lim_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register stage
   logic               in_valid_ff;
   sdspi_pkg::req_type in_ff;
   logic               out_valid_ff;
   sdspi_pkg::rsp_type out_ff;
   logic               has_res;
   sdspi_pkg::rsp_type res;

   // stage advances when result register is empty or being drained
   logic adv;
   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else if (req_ready) in_valid_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_ff <= req_data;
   end

   // sequencer state
   sdspi_pkg::phase_type phase_ff, phase_in;
   logic [47:0] frame_ff, frame_in;
   logic [9:0]  bcnt_ff, bcnt_in;
   logic [3:0]  poll_ff, poll_in;
   logic [7:0]  retry_ff, retry_in;
   logic [15:0] ms_ff, ms_in;
   logic [1:0]  ctype_ff, ctype_in;

   logic [5:0] cur_cmd;
   assign cur_cmd = frame_ff[45:40];

   // frame byte selection by byte index 0..5
   function automatic logic [7:0] fbyte(input logic [47:0] f, input logic [9:0] i);
      logic [7:0] r;
      case (i[2:0])
         3'd0: r = f[47:40];
         3'd1: r = f[39:32];
         3'd2: r = f[31:24];
         3'd3: r = f[23:16];
         3'd4: r = f[15:8];
         default: r = f[7:0];
      endcase
      return r;
   endfunction

   function automatic logic [47:0] mkframe(input logic [5:0] c, input logic [31:0] a);
      return {2'b01, c, a, (c == sdspi_pkg::CMD0) ? 8'h95 : 8'h87};
   endfunction

   function automatic logic is_init(input logic [5:0] c);
      return c == sdspi_pkg::CMD0 || c == sdspi_pkg::CMD8 || c == sdspi_pkg::CMD55 ||
             c == sdspi_pkg::CMD41 || c == sdspi_pkg::CMD58;
   endfunction

   logic [7:0]  b;
   logic [31:0] addr;
   // exchange request built up by the branches
   logic        x_v, x_cs;
   logic [7:0]  x_mosi;
   logic        do_start;
   logic [5:0]  st_cmd;
   logic [31:0] st_arg;
   logic        do_stop, stop_ok;
   logic        r_v, d_req, dn, dn_ok;
   logic        resp_hit;

   always_comb begin
      phase_in = phase_ff;
      frame_in = frame_ff;
      bcnt_in  = bcnt_ff;
      poll_in  = poll_ff;
      retry_in = retry_ff;
      ms_in    = ms_ff;
      ctype_in = ctype_ff;
      x_v = 1'b0; x_cs = 1'b0; x_mosi = 8'hFF;
      do_start = 1'b0; st_cmd = sdspi_pkg::CMD0; st_arg = '0;
      do_stop = 1'b0; stop_ok = 1'b0;
      r_v = 1'b0; d_req = 1'b0; dn = 1'b0; dn_ok = 1'b0;
      b = in_ff.miso_byte;
      addr = (ctype_ff != sdspi_pkg::CARD_SDHC) ? {in_ff.block_number[22:0], 9'd0}
                                                : in_ff.block_number;
      resp_hit = !b[7] || (poll_ff >= 4'(RESPONSE_POLL_LIMIT));
      if (in_valid_ff && adv) begin
         case (in_ff.operation)
            sdspi_pkg::OP_INIT: if (phase_ff == sdspi_pkg::PH_IDLE) begin
               ms_in = '0; retry_in = '0;
               frame_in = mkframe(sdspi_pkg::CMD0, '0);
               phase_in = sdspi_pkg::PH_WAKE; bcnt_in = '0;
               x_v = 1'b1; x_cs = 1'b1;
            end
            sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE: if (phase_ff == sdspi_pkg::PH_IDLE) begin
               do_start = 1'b1;
               st_cmd = (in_ff.operation == sdspi_pkg::OP_READ) ? sdspi_pkg::CMD17
                                                                : sdspi_pkg::CMD24;
               st_arg = addr;
            end
            sdspi_pkg::OP_TICK: if (ms_ff != 16'hFFFF) ms_in = ms_ff + 16'd1;
            sdspi_pkg::OP_WDATA: if (phase_ff == sdspi_pkg::PH_WR_WAIT) begin
               phase_in = sdspi_pkg::PH_WR_DATA;
               x_v = 1'b1; x_mosi = in_ff.write_byte;
            end
            sdspi_pkg::OP_XCHG: begin
               case (phase_ff)
                  sdspi_pkg::PH_WAKE: begin
                     bcnt_in = bcnt_ff + 10'd1;
                     if (bcnt_in < 10'(WAKE_DUMMY_BYTES)) begin
                        x_v = 1'b1; x_cs = 1'b1;
                     end else begin
                        phase_in = sdspi_pkg::PH_SEND; bcnt_in = '0;
                        x_v = 1'b1; x_mosi = fbyte(frame_ff, 10'd0);
                     end
                  end
                  sdspi_pkg::PH_BUSY: begin
                     x_v = 1'b1;
                     if (b == 8'hFF) begin
                        phase_in = sdspi_pkg::PH_SEND; bcnt_in = '0;
                        x_mosi = fbyte(frame_ff, 10'd0);
                     end
                  end
                  sdspi_pkg::PH_SEND: begin
                     bcnt_in = bcnt_ff + 10'd1; x_v = 1'b1;
                     if (bcnt_in < 10'd6) x_mosi = fbyte(frame_ff, bcnt_in);
                     else phase_in = sdspi_pkg::PH_FILL;
                  end
                  sdspi_pkg::PH_FILL: begin
                     phase_in = sdspi_pkg::PH_POLL; poll_in = '0; x_v = 1'b1;
                  end
                  sdspi_pkg::PH_POLL: begin
                     if (!resp_hit) begin
                        poll_in = poll_ff + 4'd1; x_v = 1'b1;
                     end else begin
                        case (cur_cmd)
                           sdspi_pkg::CMD0:
                              if (b == 8'h01) begin
                                 do_start = 1'b1; st_cmd = sdspi_pkg::CMD8;
                                 st_arg = 32'h1AA;
                              end else if (retry_ff >= retry_lim_ff) do_stop = 1'b1;
                              else begin
                                 retry_in = retry_ff + 8'd1; do_start = 1'b1;
                              end
                           sdspi_pkg::CMD8:
                              if (b == 8'h05) begin
                                 ctype_in = sdspi_pkg::CARD_SD1;
                                 do_start = 1'b1; st_cmd = sdspi_pkg::CMD55;
                              end else begin
                                 phase_in = sdspi_pkg::PH_OCR8; bcnt_in = '0;
                                 x_v = 1'b1;
                              end
                           sdspi_pkg::CMD55: begin
                              do_start = 1'b1; st_cmd = sdspi_pkg::CMD41;
                              st_arg = (ctype_ff == sdspi_pkg::CARD_SD2) ? 32'h40000000 : '0;
                           end
                           sdspi_pkg::CMD41:
                              if (b == 8'h00) begin
                                 if (ctype_ff == sdspi_pkg::CARD_SD2) begin
                                    do_start = 1'b1; st_cmd = sdspi_pkg::CMD58;
                                 end else begin
                                    do_stop = 1'b1; stop_ok = 1'b1;
                                 end
                              end else if (ms_ff > init_to_ff) do_stop = 1'b1;
                              else begin
                                 do_start = 1'b1; st_cmd = sdspi_pkg::CMD55;
                              end
                           sdspi_pkg::CMD58:
                              if (b != 8'h00) do_stop = 1'b1;
                              else begin
                                 phase_in = sdspi_pkg::PH_OCR58; bcnt_in = '0;
                                 x_v = 1'b1;
                              end
                           sdspi_pkg::CMD17:
                              if (b != 8'h00) do_stop = 1'b1;
                              else begin
                                 ms_in = '0; phase_in = sdspi_pkg::PH_RD_TOKEN;
                                 x_v = 1'b1;
                              end
                           sdspi_pkg::CMD24:
                              if (b != 8'h00) do_stop = 1'b1;
                              else begin
                                 phase_in = sdspi_pkg::PH_WR_TOKEN;
                                 x_v = 1'b1; x_mosi = 8'hFE;
                              end
                           sdspi_pkg::CMD13:
                              if (b != 8'h00) do_stop = 1'b1;
                              else begin
                                 phase_in = sdspi_pkg::PH_R2; x_v = 1'b1;
                              end
                           default: do_stop = 1'b1;
                        endcase
                     end
                  end
                  sdspi_pkg::PH_OCR8: begin
                     bcnt_in = bcnt_ff + 10'd1;
                     if (bcnt_in < 10'd4) x_v = 1'b1;
                     else if (b == 8'hAA) begin
                        ctype_in = sdspi_pkg::CARD_SD2;
                        do_start = 1'b1; st_cmd = sdspi_pkg::CMD55;
                     end else do_stop = 1'b1;
                  end
                  sdspi_pkg::PH_OCR58: begin
                     if (bcnt_ff == '0 && b[7:6] == 2'b11) ctype_in = sdspi_pkg::CARD_SDHC;
                     bcnt_in = bcnt_ff + 10'd1;
                     if (bcnt_in < 10'd4) x_v = 1'b1;
                     else begin
                        do_stop = 1'b1; stop_ok = 1'b1;
                     end
                  end
                  sdspi_pkg::PH_RD_TOKEN: begin
                     if (b == 8'hFF) begin
                        if (ms_ff > rd_tok_to_ff) do_stop = 1'b1;
                        else x_v = 1'b1;
                     end else if (b == 8'hFE) begin
                        phase_in = sdspi_pkg::PH_RD_DATA; bcnt_in = '0; x_v = 1'b1;
                     end else do_stop = 1'b1;
                  end
                  sdspi_pkg::PH_RD_DATA: begin
                     r_v = 1'b1; x_v = 1'b1;
                     bcnt_in = bcnt_ff + 10'd1;
                     if (bcnt_ff == 10'(sdspi_pkg::BLOCK_BYTES - 1)) begin
                        phase_in = sdspi_pkg::PH_RD_CRC; bcnt_in = '0;
                     end
                  end
                  sdspi_pkg::PH_RD_CRC: begin
                     bcnt_in = bcnt_ff + 10'd1;
                     if (bcnt_in < 10'd2) x_v = 1'b1;
                     else begin
                        do_stop = 1'b1; stop_ok = 1'b1;
                     end
                  end
                  sdspi_pkg::PH_WR_TOKEN: begin
                     phase_in = sdspi_pkg::PH_WR_WAIT; bcnt_in = '0; d_req = 1'b1;
                  end
                  sdspi_pkg::PH_WR_DATA: begin
                     if (bcnt_ff != 10'(sdspi_pkg::BLOCK_BYTES - 1)) begin
                        bcnt_in = bcnt_ff + 10'd1;
                        phase_in = sdspi_pkg::PH_WR_WAIT; d_req = 1'b1;
                     end else begin
                        phase_in = sdspi_pkg::PH_WR_CRC; bcnt_in = '0; x_v = 1'b1;
                     end
                  end
                  sdspi_pkg::PH_WR_CRC: begin
                     bcnt_in = bcnt_ff + 10'd1; x_v = 1'b1;
                     if (bcnt_in >= 10'd2) phase_in = sdspi_pkg::PH_WR_RESP;
                  end
                  sdspi_pkg::PH_WR_RESP: begin
                     if (b[4:0] != 5'h05) do_stop = 1'b1;
                     else begin
                        phase_in = sdspi_pkg::PH_WR_BUSY; ms_in = '0; x_v = 1'b1;
                     end
                  end
                  sdspi_pkg::PH_WR_BUSY: begin
                     if (b == 8'hFF) begin
                        do_start = 1'b1; st_cmd = sdspi_pkg::CMD13;
                     end else if (ms_ff > wr_busy_to_ff) do_stop = 1'b1;
                     else x_v = 1'b1;
                  end
                  sdspi_pkg::PH_R2: begin
                     do_stop = 1'b1; stop_ok = (b == 8'h00);
                  end
                  sdspi_pkg::PH_STOP_OK, sdspi_pkg::PH_STOP_FAIL: begin
                     dn = 1'b1; dn_ok = (phase_ff == sdspi_pkg::PH_STOP_OK);
                     phase_in = sdspi_pkg::PH_IDLE;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
         // command start: cmd0 goes straight to sending, others wait for not-busy
         if (do_start) begin
            frame_in = mkframe(st_cmd, st_arg);
            x_v = 1'b1; x_cs = 1'b0;
            if (st_cmd == sdspi_pkg::CMD0) begin
               phase_in = sdspi_pkg::PH_SEND; bcnt_in = '0;
               x_mosi = frame_in[47:40];
            end else begin
               phase_in = sdspi_pkg::PH_BUSY; x_mosi = 8'hFF;
            end
         end
         if (do_stop) begin
            phase_in = stop_ok ? sdspi_pkg::PH_STOP_OK : sdspi_pkg::PH_STOP_FAIL;
            x_v = 1'b1; x_cs = 1'b1; x_mosi = 8'hFF;
         end
      end
      // slow clock follows the command held after this step
      res.transfer_valid   = x_v;
      res.mosi_byte        = x_v ? x_mosi : 8'hFF;
      res.chip_select_high = x_v ? x_cs : 1'b1;
      res.slow_clock       = x_v && is_init(frame_in[45:40]);
      res.read_valid       = r_v;
      res.read_byte        = r_v ? b : 8'h00;
      res.data_request     = d_req;
      res.done_res         = dn;
      res.success          = dn && dn_ok;
      res.card_kind        = ctype_in;
      has_res = x_v || r_v || d_req || dn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdspi_pkg::PH_IDLE;
         frame_ff <= '0;
         bcnt_ff  <= '0;
         poll_ff  <= '0;
         retry_ff <= '0;
         ms_ff    <= '0;
         ctype_ff <= sdspi_pkg::CARD_UNKNOWN;
      end else begin
         phase_ff <= phase_in;
         frame_ff <= frame_in;
         bcnt_ff  <= bcnt_in;
         poll_ff  <= poll_in;
         retry_ff <= retry_in;
         ms_ff    <= ms_in;
         ctype_ff <= ctype_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (adv) out_valid_ff <= in_valid_ff && has_res;
   end
   always_ff @(posedge clock) begin
      if (adv && in_valid_ff && has_res) out_ff <= res;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

// ===== rtl/core/sdspi_checker.sv =====
// sdspi_checker: port-level checks for the sequencer
// depends on sdspi_pkg and sd_card_spi_host_sequencer_unit
module sdspi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input sdspi_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled while result side is free");

   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.transfer_valid |->
         rsp_data.mosi_byte == 8'hFF && rsp_data.chip_select_high && !rsp_data.slow_clock)
      else $error("idle exchange fields wrong");

   a_success_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.success |-> rsp_data.done_res)
      else $error("success without done");

   a_done_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.transfer_valid && !rsp_data.read_valid
         && !rsp_data.data_request)
      else $error("done mixed with other work");

endmodule

bind sd_card_spi_host_sequencer_unit sdspi_checker u_sdspi_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data));

// ===== bench/sd_card_spi_host_sequencer_unit_tb.sv =====
// sd_card_spi_host_sequencer_unit_tb: self-checking bench for the sd card spi host sequencer
// depends on sdspi_pkg and sd_card_spi_host_sequencer_unit; a small card model picks
// miso bytes from the predicted sequencer phase so init, read and write run to the end
module sd_card_spi_host_sequencer_unit_tb;

   // predicted behavior of the sequencer plus the queue of results it should give
   class spi_host_scoreboard;
      logic [15:0] wbusy_limit = 16'd600;
      logic [15:0] rtok_limit  = 16'd300;
      logic [15:0] init_limit  = 16'd2000;
      logic [7:0]  retry_limit = 8'd10;

      sdspi_pkg::phase_type ph = sdspi_pkg::PH_IDLE;
      logic [47:0] frame = '0;
      int unsigned bcnt = 0;
      int unsigned pcnt = 0;
      logic [7:0]  retries = '0;
      logic [15:0] elapsed = '0;
      logic [1:0]  ctype = sdspi_pkg::CARD_UNKNOWN;
      logic [31:0] addr = '0;

      sdspi_pkg::rsp_type cur;
      sdspi_pkg::rsp_type pending_rsp[$];
      int          errors = 0;
      int          results = 0;
      int          ok_done = 0;
      int          fail_done = 0;

      function void set_reg(logic [1:0] idx, logic [15:0] val);
         case (idx)
            sdspi_pkg::REG_WR_BUSY: wbusy_limit = val;
            sdspi_pkg::REG_RD_TOK:  rtok_limit = val;
            sdspi_pkg::REG_INIT:    init_limit = val;
            sdspi_pkg::REG_RETRY:   retry_limit = val[7:0];
            default: ;
         endcase
      endfunction

      function logic [5:0] cmd_idx();
         return frame[45:40];
      endfunction

      function void xfer(logic [7:0] mosi, logic cs);
         logic [5:0] c;
         c = cmd_idx();
         cur.transfer_valid = 1'b1;
         cur.mosi_byte = mosi;
         cur.chip_select_high = cs;
         cur.slow_clock = (c == sdspi_pkg::CMD0 || c == sdspi_pkg::CMD8 ||
                           c == sdspi_pkg::CMD55 || c == sdspi_pkg::CMD41 ||
                           c == sdspi_pkg::CMD58);
      endfunction

      function logic [7:0] frame_byte(int unsigned i);
         return frame[8 * (5 - (i % 6)) +: 8];
      endfunction

      function void send_first();
         ph = sdspi_pkg::PH_SEND;
         bcnt = 0;
         xfer(frame_byte(0), 1'b0);
      endfunction

      function void start_cmd(logic [5:0] cmd, logic [31:0] arg);
         frame = {2'b01, cmd, arg, (cmd == sdspi_pkg::CMD0) ? 8'h95 : 8'h87};
         if (cmd == sdspi_pkg::CMD0) send_first();
         else begin
            ph = sdspi_pkg::PH_BUSY;
            xfer(8'hFF, 1'b0);
         end
      endfunction

      function void stop(bit ok);
         ph = ok ? sdspi_pkg::PH_STOP_OK : sdspi_pkg::PH_STOP_FAIL;
         xfer(8'hFF, 1'b1);
      endfunction

      // card response to the command held in the frame
      function void on_response(logic [7:0] r);
         case (cmd_idx())
            sdspi_pkg::CMD0:
               if (r == 8'h01) start_cmd(sdspi_pkg::CMD8, 32'h1AA);
               else if (retries >= retry_limit) stop(0);
               else begin
                  retries++;
                  start_cmd(sdspi_pkg::CMD0, '0);
               end
            sdspi_pkg::CMD8:
               if (r == 8'h05) begin
                  ctype = sdspi_pkg::CARD_SD1;
                  start_cmd(sdspi_pkg::CMD55, '0);
               end else begin
                  ph = sdspi_pkg::PH_OCR8;
                  bcnt = 0;
                  xfer(8'hFF, 1'b0);
               end
            sdspi_pkg::CMD55:
               start_cmd(sdspi_pkg::CMD41,
                         (ctype == sdspi_pkg::CARD_SD2) ? 32'h4000_0000 : 32'h0);
            sdspi_pkg::CMD41:
               if (r == 8'h00) begin
                  if (ctype == sdspi_pkg::CARD_SD2) start_cmd(sdspi_pkg::CMD58, '0);
                  else stop(1);
               end else if (elapsed > init_limit) stop(0);
               else start_cmd(sdspi_pkg::CMD55, '0);
            sdspi_pkg::CMD58:
               if (r != 0) stop(0);
               else begin
                  ph = sdspi_pkg::PH_OCR58;
                  bcnt = 0;
                  xfer(8'hFF, 1'b0);
               end
            sdspi_pkg::CMD17:
               if (r != 0) stop(0);
               else begin
                  elapsed = '0;
                  ph = sdspi_pkg::PH_RD_TOKEN;
                  xfer(8'hFF, 1'b0);
               end
            sdspi_pkg::CMD24:
               if (r != 0) stop(0);
               else begin
                  ph = sdspi_pkg::PH_WR_TOKEN;
                  xfer(8'hFE, 1'b0);
               end
            sdspi_pkg::CMD13:
               if (r != 0) stop(0);
               else begin
                  ph = sdspi_pkg::PH_R2;
                  xfer(8'hFF, 1'b0);
               end
            default: stop(0);
         endcase
      endfunction

      function void exchanged(logic [7:0] b);
         case (ph)
            sdspi_pkg::PH_WAKE: begin
               bcnt++;
               if (bcnt < 10) xfer(8'hFF, 1'b1);
               else send_first();
            end
            sdspi_pkg::PH_BUSY:
               if (b == 8'hFF) send_first();
               else xfer(8'hFF, 1'b0);
            sdspi_pkg::PH_SEND: begin
               bcnt++;
               if (bcnt < 6) xfer(frame_byte(bcnt), 1'b0);
               else begin
                  ph = sdspi_pkg::PH_FILL;
                  xfer(8'hFF, 1'b0);
               end
            end
            sdspi_pkg::PH_FILL: begin
               ph = sdspi_pkg::PH_POLL;
               pcnt = 0;
               xfer(8'hFF, 1'b0);
            end
            sdspi_pkg::PH_POLL:
               if (!b[7] || pcnt >= 10) on_response(b);
               else begin
                  pcnt++;
                  xfer(8'hFF, 1'b0);
               end
            sdspi_pkg::PH_OCR8: begin
               bcnt++;
               if (bcnt < 4) xfer(8'hFF, 1'b0);
               else if (b == 8'hAA) begin
                  ctype = sdspi_pkg::CARD_SD2;
                  start_cmd(sdspi_pkg::CMD55, '0);
               end else stop(0);
            end
            sdspi_pkg::PH_OCR58: begin
               if (bcnt == 0 && b[7:6] == 2'b11) ctype = sdspi_pkg::CARD_SDHC;
               bcnt++;
               if (bcnt < 4) xfer(8'hFF, 1'b0);
               else stop(1);
            end
            sdspi_pkg::PH_RD_TOKEN:
               if (b == 8'hFF) begin
                  if (elapsed > rtok_limit) stop(0);
                  else xfer(8'hFF, 1'b0);
               end else if (b == 8'hFE) begin
                  ph = sdspi_pkg::PH_RD_DATA;
                  bcnt = 0;
                  xfer(8'hFF, 1'b0);
               end else stop(0);
            sdspi_pkg::PH_RD_DATA: begin
               cur.read_valid = 1'b1;
               cur.read_byte = b;
               bcnt++;
               if (bcnt >= sdspi_pkg::BLOCK_BYTES) begin
                  ph = sdspi_pkg::PH_RD_CRC;
                  bcnt = 0;
               end
               xfer(8'hFF, 1'b0);
            end
            sdspi_pkg::PH_RD_CRC: begin
               bcnt++;
               if (bcnt < 2) xfer(8'hFF, 1'b0);
               else stop(1);
            end
            sdspi_pkg::PH_WR_TOKEN: begin
               ph = sdspi_pkg::PH_WR_WAIT;
               bcnt = 0;
               cur.data_request = 1'b1;
            end
            sdspi_pkg::PH_WR_DATA: begin
               bcnt++;
               if (bcnt < sdspi_pkg::BLOCK_BYTES) begin
                  ph = sdspi_pkg::PH_WR_WAIT;
                  cur.data_request = 1'b1;
               end else begin
                  ph = sdspi_pkg::PH_WR_CRC;
                  bcnt = 0;
                  xfer(8'hFF, 1'b0);
               end
            end
            sdspi_pkg::PH_WR_CRC: begin
               bcnt++;
               if (bcnt >= 2) ph = sdspi_pkg::PH_WR_RESP;
               xfer(8'hFF, 1'b0);
            end
            sdspi_pkg::PH_WR_RESP:
               if (b[4:0] != 5'h05) stop(0);
               else begin
                  ph = sdspi_pkg::PH_WR_BUSY;
                  elapsed = '0;
                  xfer(8'hFF, 1'b0);
               end
            sdspi_pkg::PH_WR_BUSY:
               if (b == 8'hFF) start_cmd(sdspi_pkg::CMD13, '0);
               else if (elapsed > wbusy_limit) stop(0);
               else xfer(8'hFF, 1'b0);
            sdspi_pkg::PH_R2: stop(b == 8'h00);
            sdspi_pkg::PH_STOP_OK, sdspi_pkg::PH_STOP_FAIL: begin
               cur.done_res = 1'b1;
               cur.success = (ph == sdspi_pkg::PH_STOP_OK);
               if (ph == sdspi_pkg::PH_STOP_OK) ok_done++;
               else fail_done++;
               ph = sdspi_pkg::PH_IDLE;
            end
            default: ;
         endcase
      endfunction

      // one accepted request transfer
      function void note_request(sdspi_pkg::req_type q);
         cur = '0;
         cur.mosi_byte = 8'hFF;
         cur.chip_select_high = 1'b1;
         case (q.operation)
            sdspi_pkg::OP_INIT:
               if (ph == sdspi_pkg::PH_IDLE) begin
                  elapsed = '0;
                  retries = '0;
                  frame = {2'b01, sdspi_pkg::CMD0, 32'h0, 8'h95};
                  ph = sdspi_pkg::PH_WAKE;
                  bcnt = 0;
                  xfer(8'hFF, 1'b1);
               end
            sdspi_pkg::OP_READ, sdspi_pkg::OP_WRITE:
               if (ph == sdspi_pkg::PH_IDLE) begin
                  addr = (ctype != sdspi_pkg::CARD_SDHC) ? (q.block_number << 9)
                                                         : q.block_number;
                  start_cmd((q.operation == sdspi_pkg::OP_READ) ? sdspi_pkg::CMD17
                                                                : sdspi_pkg::CMD24, addr);
               end
            sdspi_pkg::OP_XCHG: exchanged(q.miso_byte);
            sdspi_pkg::OP_TICK: if (elapsed != 16'hFFFF) elapsed++;
            sdspi_pkg::OP_WDATA:
               if (ph == sdspi_pkg::PH_WR_WAIT) begin
                  ph = sdspi_pkg::PH_WR_DATA;
                  xfer(q.write_byte, 1'b0);
               end
            default: ;
         endcase
         cur.card_kind = ctype;
         if (cur.transfer_valid || cur.read_valid || cur.data_request || cur.done_res)
            pending_rsp.push_back(cur);
      endfunction

      // one accepted result transfer against the oldest prediction
      function void check_result(sdspi_pkg::rsp_type got);
         sdspi_pkg::rsp_type want;
         results++;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %h", got);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.transfer_valid !== want.transfer_valid || got.mosi_byte !== want.mosi_byte ||
             got.chip_select_high !== want.chip_select_high ||
             got.slow_clock !== want.slow_clock || got.read_valid !== want.read_valid ||
             got.read_byte !== want.read_byte || got.data_request !== want.data_request ||
             got.done_res !== want.done_res || got.success !== want.success ||
             got.card_kind !== want.card_kind) begin
            errors++;
            if (errors <= 10)
               $display("mismatch at result %0d: xv/mosi/cs/slow/rv/rb/dreq/done/ok/kind ",
                        results,
                        "exp %b %h %b %b %b %h %b %b %b %0d ",
                        want.transfer_valid, want.mosi_byte, want.chip_select_high,
                        want.slow_clock, want.read_valid, want.read_byte, want.data_request,
                        want.done_res, want.success, want.card_kind,
                        "got %b %h %b %b %b %h %b %b %b %0d",
                        got.transfer_valid, got.mosi_byte, got.chip_select_high,
                        got.slow_clock, got.read_valid, got.read_byte, got.data_request,
                        got.done_res, got.success, got.card_kind);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sdspi_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sdspi_pkg::rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   spi_host_scoreboard sb = new();
   int          burst_left = 0;
   int          items_sent = 0;
   int unsigned cycle_count = 0;

   sd_card_spi_host_sequencer_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // receiver: alternating free-running and random stall stretches, with one long hold-off
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (rsp_valid && rsp_ready) sb.check_result(rsp_data);
      if (reset) rsp_ready <= 1'b0;
      else if (cycle_count >= 1500 && cycle_count < 1900) rsp_ready <= 1'b0;
      else if (cycle_count[6]) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(2) != 0);
   end

   // card model: picks the next item from the predicted phase, with some noise
   function automatic sdspi_pkg::req_type pick_item();
      sdspi_pkg::req_type q;
      int      r;
      q.operation = sdspi_pkg::OP_XCHG;
      q.block_number = $urandom;
      q.miso_byte = 8'($urandom);
      q.write_byte = 8'($urandom);
      if ($urandom_range(99) < 8) begin
         // noise: stray exchanges, ticks, unused codes, requests while busy
         q.operation = 3'($urandom_range(7));
         return q;
      end
      r = $urandom_range(9);
      case (sb.ph)
         sdspi_pkg::PH_IDLE: begin
            q.operation = (r < 4) ? sdspi_pkg::OP_INIT :
                          (r < 7) ? sdspi_pkg::OP_READ : sdspi_pkg::OP_WRITE;
            case ($urandom_range(3))
               0: q.block_number = '0;
               1: q.block_number = '1;
               default: ;
            endcase
         end
         sdspi_pkg::PH_WR_WAIT: q.operation = sdspi_pkg::OP_WDATA;
         sdspi_pkg::PH_BUSY: if (r < 8) q.miso_byte = 8'hFF;
         sdspi_pkg::PH_POLL:
            if (r < 3) q.miso_byte = 8'hFF;
            else if (r < 9) begin
               case (sb.cmd_idx())
                  sdspi_pkg::CMD0:
                     q.miso_byte = ($urandom_range(5) != 0) ? 8'h01 : 8'h00;
                  sdspi_pkg::CMD8:
                     q.miso_byte = ($urandom_range(3) != 0) ? 8'h01 : 8'h05;
                  sdspi_pkg::CMD55: q.miso_byte = 8'h01;
                  sdspi_pkg::CMD41:
                     q.miso_byte = ($urandom_range(2) == 0) ? 8'h00 : 8'h01;
                  default: q.miso_byte = ($urandom_range(7) != 0) ? 8'h00 : 8'h04;
               endcase
            end
         sdspi_pkg::PH_OCR8: if (sb.bcnt == 3 && r < 8) q.miso_byte = 8'hAA;
         sdspi_pkg::PH_OCR58: if (sb.bcnt == 0 && r < 5) q.miso_byte[7:6] = 2'b11;
         sdspi_pkg::PH_RD_TOKEN:
            if (r < 2) q.operation = sdspi_pkg::OP_TICK;
            else if (r < 4) q.miso_byte = 8'hFF;
            else if (r < 9) q.miso_byte = 8'hFE;
         sdspi_pkg::PH_WR_RESP: if (r < 8) q.miso_byte[4:0] = 5'h05;
         sdspi_pkg::PH_WR_BUSY:
            if (r < 3) q.operation = sdspi_pkg::OP_TICK;
            else if (r < 6) q.miso_byte = 8'h00;
            else q.miso_byte = 8'hFF;
         sdspi_pkg::PH_R2: if (r < 8) q.miso_byte = 8'h00;
         default: ;
      endcase
      return q;
   endfunction

   // one request transfer, with bursts and random gaps between them
   task automatic send_item(sdspi_pkg::req_type q);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(6);
         if (gap != 0) begin
            if (req_valid) req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      sb.note_request(q);
      items_sent++;
      burst_left--;
   endtask

   task automatic run_random(int count);
      repeat (count) send_item(pick_item());
   endtask

   // sender pause: drop valid and wait until every predicted result has come
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic write_all(logic [15:0] wb, logic [15:0] rt, logic [15:0] it, logic [7:0] rl);
      write_reg(sdspi_pkg::REG_WR_BUSY, wb);
      write_reg(sdspi_pkg::REG_RD_TOK, rt);
      write_reg(sdspi_pkg::REG_INIT, it);
      write_reg(sdspi_pkg::REG_RETRY, {8'h00, rl});
   endtask

   task automatic directed();
      sdspi_pkg::req_type q;
      q = '0;
      // stray inputs from idle: exchange, write data, unused codes, tick
      q.operation = sdspi_pkg::OP_XCHG;  q.miso_byte = 8'hFF; send_item(q);
      q.operation = sdspi_pkg::OP_WDATA; q.write_byte = 8'hFF; send_item(q);
      q.operation = 3'd6; send_item(q);
      q.operation = 3'd7; q.block_number = '1; send_item(q);
      q.operation = sdspi_pkg::OP_TICK; send_item(q);
      // init, then requests while busy are ignored
      q.operation = sdspi_pkg::OP_INIT; send_item(q);
      q.operation = sdspi_pkg::OP_READ; send_item(q);
      q.operation = sdspi_pkg::OP_WRITE; send_item(q);
      q.operation = sdspi_pkg::OP_INIT; send_item(q);
      // wake clocks, then cmd0 is sent and polling for its answer begins
      q.operation = sdspi_pkg::OP_XCHG;
      q.miso_byte = 8'h00;
      repeat (17) send_item(q);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed();
      run_random(300);
      drain();
      // zero limits: every timeout fires after the first tick, no cmd0 retries
      write_all(16'h0000, 16'h0000, 16'h0000, 8'h00);
      run_random(300);
      drain();
      // largest limits
      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
      run_random(300);
      drain();
      write_all(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                16'($urandom_range(1, 20)), 8'($urandom_range(1, 4)));
      run_random(300);
      drain();
      repeat (20) @(posedge clock);
      $display("sent %0d request transfers, checked %0d results, %0d ops ok and %0d failed",
               items_sent, sb.results, sb.ok_done, sb.fail_done);
      $display("four limit settings, mismatches %0d, leftover %0d",
               sb.errors, sb.pending_rsp.size());
      if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // run limit
   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", sb.pending_rsp.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
